// File: rtl/core/nsd_pkg.sv
// Shared types and constants for the noise-shaped audio dither.
// No dependencies; used by every other file of the block.
package nsd_pkg;

  localparam int unsigned SAMPLE_IN_W  = 32;
  localparam int unsigned SAMPLE_OUT_W = 30;
  localparam int unsigned CFG_DATA_W   = 4;
  localparam int unsigned CFG_IDX_W    = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

  // dither modes
  localparam logic [1:0] MODE_PASS     = 2'd0;
  localparam logic [1:0] MODE_DITHER8  = 2'd1;
  localparam logic [1:0] MODE_DITHER16 = 2'd2;

  localparam logic [1:0] DITHER_MODE_RESET   = MODE_PASS;
  localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd2;

  // noise generator
  localparam logic [31:0] LCG_MUL = 32'h0019_660d;
  localparam logic [31:0] LCG_INC = 32'h3c6e_f35f;

  // Q3.28 limits, 32 and 34 bit views
  localparam logic signed [31:0] ONE_Q28_32     = 32'sh1000_0000;
  localparam logic signed [31:0] NEG_ONE_Q28_32 = 32'shF000_0000;
  localparam logic signed [33:0] ONE_Q28_34     = 34'sh0_1000_0000;
  localparam logic signed [33:0] NEG_ONE_Q28_34 = 34'sh3_F000_0000;
  localparam logic signed [33:0] SAT_MAX_34     = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_MIN_34     = 34'sh3_8000_0000;

  // one target LSB in Q3.28
  localparam logic signed [33:0] LSB_8BIT_34  = 34'sh0_0020_0000;
  localparam logic signed [33:0] LSB_16BIT_34 = 34'sh0_0000_2000;

  typedef struct packed {
    logic signed [31:0] err_recent;
    logic signed [31:0] err_halved;
    logic signed [31:0] err_oldest;
    logic        [31:0] noise_seed;
  } chan_state_t;

endpackage

// File: rtl/core/nsd_if.sv
// Handshake channels of the dither block: sample input and sample output.
// Depends on nsd_pkg for payload widths.
interface nsd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [nsd_pkg::SAMPLE_IN_W-1:0] sample_in;
  logic                                   last_in_buffer;

  modport source (output valid, output sample_in, output last_in_buffer, input ready);
  modport sink (input valid, input sample_in, input last_in_buffer, output ready);
endinterface

interface nsd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [nsd_pkg::SAMPLE_OUT_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// File: rtl/core/nsd_chan_regs.sv
// Per-channel error history and noise seed registers.
// Depends on nsd_pkg (chan_state_t). One read port, one write port.
module nsd_chan_regs #(
  parameter int unsigned NumCh = 8,
  parameter int unsigned ChW   = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ChW-1:0]       rd_ch_i,
  output nsd_pkg::chan_state_t rd_state_o,
  input  logic                 we_i,
  input  logic [ChW-1:0]       wr_ch_i,
  input  nsd_pkg::chan_state_t wr_state_i
);

  nsd_pkg::chan_state_t state_q [NumCh];

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        state_q[c] <= '0;
      end else if (we_i && (wr_ch_i == ChW'(c))) begin
        state_q[c] <= wr_state_i;
      end
    end
  end

  assign rd_state_o = state_q[rd_ch_i];

endmodule

// File: rtl/core/nsd_shaper.sv
// Dither datapath for one sample: error shaping, LCG noise, bias, clipping.
// Depends on nsd_pkg. Purely combinational; sits between input and result regs.
module nsd_shaper (
  input  logic [1:0]                              mode_i,
  input  logic signed [nsd_pkg::SAMPLE_IN_W-1:0]  sample_i,
  input  nsd_pkg::chan_state_t                    state_i,
  output logic signed [nsd_pkg::SAMPLE_OUT_W-1:0] sample_o,
  output logic                                    state_we_o,
  output nsd_pkg::chan_state_t                    state_o
);

  logic               dither_en;
  logic [31:0]        seed_next;
  logic [31:0]        noise_diff;
  logic signed [33:0] noise;
  logic signed [33:0] lsb;
  logic signed [33:0] shaped_sum;
  logic signed [33:0] shaped_sat;
  logic signed [33:0] dith_sum;
  logic signed [33:0] dith_clip;
  logic signed [33:0] shaped_clip;
  logic signed [33:0] err_full;
  logic signed [31:0] err_sat;
  logic signed [31:0] pass_clip;
  logic signed [31:0] e0_adj;

  assign dither_en = (mode_i == nsd_pkg::MODE_DITHER8) || (mode_i == nsd_pkg::MODE_DITHER16);

  assign seed_next  = state_i.noise_seed * nsd_pkg::LCG_MUL + nsd_pkg::LCG_INC;
  assign noise_diff = seed_next - state_i.noise_seed;

  always_comb begin
    if (mode_i == nsd_pkg::MODE_DITHER8) begin
      lsb   = nsd_pkg::LSB_8BIT_34;
      noise = $signed({13'b0, noise_diff[31:11]});
    end else begin
      lsb   = nsd_pkg::LSB_16BIT_34;
      noise = $signed({21'b0, noise_diff[31:19]});
    end
  end

  assign shaped_sum = $signed({{2{sample_i[31]}}, sample_i})
                    + $signed({{2{state_i.err_recent[31]}}, state_i.err_recent})
                    - $signed({{2{state_i.err_halved[31]}}, state_i.err_halved})
                    + $signed({{2{state_i.err_oldest[31]}}, state_i.err_oldest});

  always_comb begin
    if (shaped_sum > nsd_pkg::SAT_MAX_34) begin
      shaped_sat = nsd_pkg::SAT_MAX_34;
    end else if (shaped_sum < nsd_pkg::SAT_MIN_34) begin
      shaped_sat = nsd_pkg::SAT_MIN_34;
    end else begin
      shaped_sat = shaped_sum;
    end
  end

  assign dith_sum = shaped_sat + lsb + noise;

  // clipping the output also pulls the shaped value into range on that side
  always_comb begin
    dith_clip   = dith_sum;
    shaped_clip = shaped_sat;
    if (dith_sum > nsd_pkg::ONE_Q28_34) begin
      dith_clip = nsd_pkg::ONE_Q28_34;
      if (shaped_sat > nsd_pkg::ONE_Q28_34) begin
        shaped_clip = nsd_pkg::ONE_Q28_34;
      end
    end else if (dith_sum < nsd_pkg::NEG_ONE_Q28_34) begin
      dith_clip = nsd_pkg::NEG_ONE_Q28_34;
      if (shaped_sat < nsd_pkg::NEG_ONE_Q28_34) begin
        shaped_clip = nsd_pkg::NEG_ONE_Q28_34;
      end
    end
  end

  assign err_full = shaped_clip - dith_clip;

  always_comb begin
    if (err_full > nsd_pkg::SAT_MAX_34) begin
      err_sat = nsd_pkg::SAT_MAX_34[31:0];
    end else if (err_full < nsd_pkg::SAT_MIN_34) begin
      err_sat = nsd_pkg::SAT_MIN_34[31:0];
    end else begin
      err_sat = err_full[31:0];
    end
  end

  always_comb begin
    if (sample_i > nsd_pkg::ONE_Q28_32) begin
      pass_clip = nsd_pkg::ONE_Q28_32;
    end else if (sample_i < nsd_pkg::NEG_ONE_Q28_32) begin
      pass_clip = nsd_pkg::NEG_ONE_Q28_32;
    end else begin
      pass_clip = sample_i;
    end
  end

  // halve toward zero: add one before the shift for negative values
  assign e0_adj = state_i.err_recent + $signed({31'b0, state_i.err_recent[31]});

  assign state_o.err_recent = err_sat;
  assign state_o.err_halved = e0_adj >>> 1;
  assign state_o.err_oldest = state_i.err_halved;
  assign state_o.noise_seed = seed_next;

  assign state_we_o = dither_en;
  assign sample_o   = dither_en ? dith_clip[nsd_pkg::SAMPLE_OUT_W-1:0]
                                : pass_clip[nsd_pkg::SAMPLE_OUT_W-1:0];

endmodule

// File: rtl/core/noise_shaped_audio_dither.sv
// Noise-shaped audio dither, top level: input register, shaper, result register.
// Each accepted sample passes the input register and then the result register, which holds it
// while the output stalls. Throughput: one sample per cycle while the output is not stalled; the
// channel state is read and rewritten in the same cycle, so consecutive samples of one channel follow without a gap.
// Reset clears all channel history, seeds and the channel position; mode 0, two channels.
// Depends on nsd_pkg, nsd_if, nsd_chan_regs, nsd_shaper.
module noise_shaped_audio_dither #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nsd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nsd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  nsd_in_if.sink                            in_if,
  nsd_out_if.source                         out_if
);

  localparam int unsigned ChW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CmpW = ((CntW > nsd_pkg::CFG_DATA_W) ? CntW
                                                               : nsd_pkg::CFG_DATA_W) + 1;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MAX_CHANNELS);

  logic [1:0]                             mode_q;
  logic [nsd_pkg::CFG_DATA_W-1:0]         count_q;
  logic [ChW-1:0]                         pos_q, pos_d;
  logic                                   in_valid_q;
  logic signed [nsd_pkg::SAMPLE_IN_W-1:0] in_sample_q;
  logic                                   in_last_q;
  logic                                   out_valid_q;
  logic signed [nsd_pkg::SAMPLE_OUT_W-1:0] out_sample_q;

  logic                                    advance;
  logic [CmpW-1:0]                         count_eff;
  logic [CmpW-1:0]                         ch_inc;
  logic [ChW-1:0]                          ch;
  nsd_pkg::chan_state_t                    cur_state;
  nsd_pkg::chan_state_t                    new_state;
  logic                                    state_we;
  logic signed [nsd_pkg::SAMPLE_OUT_W-1:0] shaped_sample;

  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = out_sample_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= nsd_pkg::DITHER_MODE_RESET;
      count_q <= nsd_pkg::CHANNEL_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nsd_pkg::REG_DITHER_MODE:   mode_q  <= cfg_data_i[1:0];
        nsd_pkg::REG_CHANNEL_COUNT: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // channel selection; zero count acts as one, large counts are capped
  always_comb begin
    if (count_q == '0) begin
      count_eff = CmpW'(1);
    end else if (CmpW'(count_q) > MaxCmp) begin
      count_eff = MaxCmp;
    end else begin
      count_eff = CmpW'(count_q);
    end
    ch     = (CmpW'(pos_q) < count_eff) ? pos_q : '0;
    ch_inc = CmpW'(ch) + CmpW'(1);
    pos_d  = (in_last_q || (ch_inc >= count_eff)) ? '0 : ch_inc[ChW-1:0];
  end

  nsd_chan_regs #(
    .NumCh (MAX_CHANNELS),
    .ChW   (ChW)
  ) u_chan_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_ch_i    (ch),
    .rd_state_o (cur_state),
    .we_i       (advance && state_we),
    .wr_ch_i    (ch),
    .wr_state_i (new_state)
  );

  nsd_shaper u_shaper (
    .mode_i     (mode_q),
    .sample_i   (in_sample_q),
    .state_i    (cur_state),
    .sample_o   (shaped_sample),
    .state_we_o (state_we),
    .state_o    (new_state)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (advance) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_sample_q <= in_if.sample_in;
      in_last_q   <= in_if.last_in_buffer;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q <= shaped_sample;
    end
  end

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result not presented after an item left the input stage");

  a_empty_input_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_if.ready)
    else $error("input stage empty but not ready");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_sample_q <= $signed(nsd_pkg::ONE_Q28_32[29:0]))
                 && (out_sample_q >= $signed(nsd_pkg::NEG_ONE_Q28_32[29:0]))))
    else $error("result outside plus or minus one");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (pos_q == '0))
    else $error("channel rotation not restarted after last word of buffer");

endmodule

// File: sim/noise_shaped_audio_dither_tb.sv
// Self-checking testbench for noise_shaped_audio_dither: a directed table, then random
// phases of samples under random modes and channel counts, checked against a local model.
// Depends on nsd_pkg, nsd_in_if, nsd_out_if and noise_shaped_audio_dither.
module noise_shaped_audio_dither_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 20;
  localparam int unsigned MAX_CH         = 8;
  localparam int unsigned QUIET_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RAND_ITEMS     = 400;
  localparam logic [1:0]  MODE_RESERVED  = 2'd3;
  localparam logic [3:0]  DATA_D8        = 4'(nsd_pkg::MODE_DITHER8);
  localparam logic [3:0]  DATA_D16       = 4'(nsd_pkg::MODE_DITHER16);

  typedef struct packed {
    logic                          is_cfg;
    logic [nsd_pkg::CFG_IDX_W-1:0] idx;
    logic [3:0]                    data;
    logic [31:0]                   sample;
    logic                          last;
    logic                          typed;
    logic [29:0]                   want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [nsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [nsd_pkg::CFG_DATA_W-1:0] cfg_data_i;

  nsd_in_if  in_ch ();
  nsd_out_if out_ch ();

  noise_shaped_audio_dither #(
    .MAX_CHANNELS(MAX_CH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // model state: per-channel error history and noise generator
  logic signed [31:0] hist_e0 [MAX_CH];
  logic signed [31:0] hist_e1 [MAX_CH];
  logic signed [31:0] hist_e2 [MAX_CH];
  logic        [31:0] lcg_state [MAX_CH];
  int unsigned        next_chan;
  logic [1:0]         cfg_mode;
  logic [3:0]         cfg_count;

  logic [29:0] dithered_q [$];
  int unsigned n_bad;
  bit          sender_burst;
  bit          sink_burst;
  bit          hold_req;
  logic [29:0] head_word;

  stim_row_t dir_tab [32] = '{
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h7FFF_FFFF, 1'b0, 1'b1, 30'h1000_0000},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h8000_0000, 1'b0, 1'b1, 30'h3000_0000},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h1000_0001, 1'b0, 1'b1, 30'h1000_0000},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'hEFFF_FFFF, 1'b0, 1'b1, 30'h3000_0000},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_0000, 1'b0, 1'b1, 30'h0000_0000},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'hF000_0000, 1'b1, 1'b1, 30'h3000_0000},
    '{1'b1, nsd_pkg::REG_DITHER_MODE,   DATA_D8,  32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b1, nsd_pkg::REG_CHANNEL_COUNT, 4'd1,     32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_0000, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h7FFF_FFFF, 1'b0, 1'b1, 30'h1000_0000},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h8000_0000, 1'b0, 1'b1, 30'h3000_0000},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_0000, 1'b0, 1'b0, 30'h0},
    '{1'b1, nsd_pkg::REG_DITHER_MODE,   DATA_D16, 32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b1, nsd_pkg::REG_CHANNEL_COUNT, 4'd8,     32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0FFF_FFF0, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'hF000_0010, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h1234_5678, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'hEDCB_A988, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_0000, 1'b0, 1'b0, 30'h0},
    // shrink below the current position: next sample falls back to channel 0
    '{1'b1, nsd_pkg::REG_CHANNEL_COUNT, 4'd3,     32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0040_0000, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'hFFC0_0000, 1'b1, 1'b0, 30'h0},
    '{1'b1, nsd_pkg::REG_CHANNEL_COUNT, 4'd0,     32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_0000, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_0000, 1'b0, 1'b0, 30'h0},
    '{1'b1, nsd_pkg::REG_CHANNEL_COUNT, 4'd15,    32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_1000, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'hFFFF_F000, 1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0000_0000, 1'b1, 1'b0, 30'h0},
    // upper data bits set: mode field gets the reserved code, which passes through
    '{1'b1, nsd_pkg::REG_DITHER_MODE,   4'hF,     32'h0,         1'b0, 1'b0, 30'h0},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h0FFF_FFFF, 1'b0, 1'b1, 30'h0FFF_FFFF},
    '{1'b0, nsd_pkg::REG_DITHER_MODE,   4'h0,     32'h8000_0000, 1'b0, 1'b1, 30'h3000_0000}
  };

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Result word for one sample; dither modes also advance the channel state.
  function automatic logic [29:0] dither_sample(logic signed [31:0] x_in, logic last_in);
    longint      x, e0, e1, e2, s, o, lsb, err;
    logic [31:0] seed, r, d;
    int unsigned cnt, ch, sh;
    x   = x_in;
    cnt = cfg_count;
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_CH) cnt = MAX_CH;
    ch = (next_chan < cnt) ? next_chan : 0;
    if (cfg_mode == nsd_pkg::MODE_DITHER8 || cfg_mode == nsd_pkg::MODE_DITHER16) begin
      sh  = (cfg_mode == nsd_pkg::MODE_DITHER8) ? 21 : 13;
      lsb = (cfg_mode == nsd_pkg::MODE_DITHER8) ? longint'(nsd_pkg::LSB_8BIT_34)
                                                : longint'(nsd_pkg::LSB_16BIT_34);
      e0  = hist_e0[ch];
      e1  = hist_e1[ch];
      e2  = hist_e2[ch];
      seed = lcg_state[ch];
      r    = seed * nsd_pkg::LCG_MUL + nsd_pkg::LCG_INC;
      d    = r - seed;
      s = limit_to(x + e0 - e1 + e2, longint'(nsd_pkg::SAT_MIN_34),
                   longint'(nsd_pkg::SAT_MAX_34));
      o = s + lsb + longint'(d >> (32 - sh));
      if (o > longint'(nsd_pkg::ONE_Q28_34)) begin
        o = nsd_pkg::ONE_Q28_34;
        if (s > longint'(nsd_pkg::ONE_Q28_34)) s = nsd_pkg::ONE_Q28_34;
      end else if (o < longint'(nsd_pkg::NEG_ONE_Q28_34)) begin
        o = nsd_pkg::NEG_ONE_Q28_34;
        if (s < longint'(nsd_pkg::NEG_ONE_Q28_34)) s = nsd_pkg::NEG_ONE_Q28_34;
      end
      err = limit_to(s - o, longint'(nsd_pkg::SAT_MIN_34), longint'(nsd_pkg::SAT_MAX_34));
      hist_e2[ch]   = e1[31:0];
      hist_e1[ch]   = 32'(e0 / 2);
      hist_e0[ch]   = err[31:0];
      lcg_state[ch] = r;
    end else begin
      o = limit_to(x, longint'(nsd_pkg::NEG_ONE_Q28_34), longint'(nsd_pkg::ONE_Q28_34));
    end
    next_chan = (last_in || ch + 1 >= cnt) ? 0 : ch + 1;
    return o[29:0];
  endfunction

  task automatic write_reg(logic [nsd_pkg::CFG_IDX_W-1:0] idx, logic [3:0] data);
    in_ch.valid <= 1'b0;
    while (dithered_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == nsd_pkg::REG_DITHER_MODE) cfg_mode = data[1:0];
    else if (idx == nsd_pkg::REG_CHANNEL_COUNT) cfg_count = data;
  endtask

  task automatic send_sample(logic [31:0] sample, logic last, logic typed, logic [29:0] want);
    int unsigned gap;
    logic [29:0] word;
    gap = sender_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_in      <= sample;
    in_ch.last_in_buffer <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    word = dither_sample(sample, last);
    dithered_q.push_back(typed ? want : word);
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = sink_burst ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (dithered_q.size() == 0) begin
        n_bad++;
        $display("%0t: unexpected word, expected none, got %h", $time, out_ch.sample_out);
      end else begin
        head_word = dithered_q.pop_front();
        if (out_ch.sample_out !== head_word) begin
          n_bad++;
          $display("%0t: sample_out expected %h, got %h", $time, head_word,
                   out_ch.sample_out);
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned n_rand, phase, n_items, buf_len, pick;
    logic [1:0]         mode;
    logic [3:0]         count;
    logic signed [31:0] x;
    logic               last;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = nsd_pkg::REG_DITHER_MODE;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.sample_in      = '0;
    in_ch.last_in_buffer = 1'b0;
    n_bad                = 0;
    sender_burst         = 1'b0;
    sink_burst           = 1'b0;
    hold_req             = 1'b0;
    cfg_mode             = nsd_pkg::DITHER_MODE_RESET;
    cfg_count            = nsd_pkg::CHANNEL_COUNT_RESET;
    next_chan            = 0;
    for (int c = 0; c < MAX_CH; c++) begin
      hist_e0[c]   = '0;
      hist_e1[c]   = '0;
      hist_e2[c]   = '0;
      lcg_state[c] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_sample(dir_tab[i].sample, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    end

    n_rand = 0;
    phase  = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) mode = nsd_pkg::MODE_PASS;
      else if (pick == 1) mode = MODE_RESERVED;
      else if (pick < 6) mode = nsd_pkg::MODE_DITHER8;
      else mode = nsd_pkg::MODE_DITHER16;
      write_reg(nsd_pkg::REG_DITHER_MODE, {2'($urandom_range(0, 3)), mode});
      count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
      write_reg(nsd_pkg::REG_CHANNEL_COUNT, count);
      sender_burst = ($urandom_range(0, 3) == 0);
      sink_burst   = ($urandom_range(0, 3) == 0);
      n_items      = $urandom_range(10, 40);
      // one phase stalls the sink for a long time while words keep coming
      if (phase == 2) begin
        sender_burst = 1'b1;
        hold_req     = 1'b1;
        n_items      = 40;
      end
      buf_len = $urandom_range(1, 24);
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: x = $urandom_range(0, 32'h5000_0000) - 32'h2800_0000;
          6:                x = $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
          7, 8:             x = $urandom;
          default: begin
            case ($urandom_range(0, 3))
              0:       x = 32'h7FFF_FFFF;
              1:       x = 32'h8000_0000;
              2:       x = nsd_pkg::ONE_Q28_32;
              default: x = nsd_pkg::NEG_ONE_Q28_32;
            endcase
          end
        endcase
        last = ((k % buf_len) == buf_len - 1) || ($urandom_range(0, 19) == 0);
        send_sample(x, last, 1'b0, '0);
      end
      n_rand += n_items;
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (dithered_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_bad == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
